// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under reset
`define SB2D_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under reset
`define SB2D_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sb2d_pkg.sv -----
// Package for the signed binary to decimal ASCII converter.
// Holds the state type, cell control struct, dabble constants and character constants; no dependencies.
package sb2d_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SIGN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic clear;
        logic dabble;
        logic shift_digit;
    } cell_ctrl_t;

    localparam int DIGIT_BITS = 4;
    localparam logic [DIGIT_BITS-1:0] DABBLE_LIMIT = 4'd5;
    localparam logic [DIGIT_BITS-1:0] DABBLE_ADD = 4'd3;
    localparam logic [7:0] CHAR_ZERO = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

endpackage

// ----- rtl/sb2d_cell.sv -----
// One BCD digit cell of the double-dabble chain.
// Depends on sb2d_pkg for the control struct and dabble constants.
module sb2d_cell (
    input  logic                                clk,
    input  sb2d_pkg::cell_ctrl_t                ctrl,
    input  logic                                bit_in,
    input  logic [sb2d_pkg::DIGIT_BITS-1:0]     digit_in,
    output logic                                bit_out,
    output logic [sb2d_pkg::DIGIT_BITS-1:0]     digit
);
    import sb2d_pkg::*;

    logic [DIGIT_BITS-1:0] digit_reg;
    logic [DIGIT_BITS-1:0] digit_next;
    logic [DIGIT_BITS-1:0] adj;

    assign adj     = (digit_reg >= DABBLE_LIMIT) ? digit_reg + DABBLE_ADD : digit_reg;
    assign bit_out = adj[DIGIT_BITS-1];
    assign digit   = digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.dabble)
        begin
            digit_next = {adj[DIGIT_BITS-2:0], bit_in};
        end
        else if (ctrl.shift_digit)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

// ----- rtl/sb2d_chain.sv -----
// Row of BCD digit cells; binary bits enter at the low end, digits leave at the top.
// Depends on sb2d_pkg and sb2d_cell.
module sb2d_chain #(
    parameter int NDIG = 10
) (
    input  logic                                clk,
    input  sb2d_pkg::cell_ctrl_t                ctrl,
    input  logic                                bin_bit,
    output logic [sb2d_pkg::DIGIT_BITS-1:0]     top_digit
);
    import sb2d_pkg::*;

    logic [DIGIT_BITS-1:0] digit_w [NDIG];
    logic                  carry_w [NDIG-1];

    genvar i;
    generate
        for (i = 0; i < NDIG; i++)
        begin : g_cell
            logic                  bit_in_w;
            logic [DIGIT_BITS-1:0] digit_in_w;

            if (i == 0)
            begin : g_low
                assign bit_in_w   = bin_bit;
                assign digit_in_w = '0;
            end
            else
            begin : g_mid
                assign bit_in_w   = carry_w[i-1];
                assign digit_in_w = digit_w[i-1];
            end

            if (i == NDIG - 1)
            begin : g_top
                sb2d_cell u_cell (
                    .clk      (clk),
                    .ctrl     (ctrl),
                    .bit_in   (bit_in_w),
                    .digit_in (digit_in_w),
                    .bit_out  (),
                    .digit    (digit_w[i])
                );
            end
            else
            begin : g_inner
                sb2d_cell u_cell (
                    .clk      (clk),
                    .ctrl     (ctrl),
                    .bit_in   (bit_in_w),
                    .digit_in (digit_in_w),
                    .bit_out  (carry_w[i]),
                    .digit    (digit_w[i])
                );
            end
        end
    endgenerate

    assign top_digit = digit_w[NDIG-1];

endmodule

// ----- rtl/signed_binary_to_decimal_ascii.sv -----
// Top level of the signed binary to decimal ASCII converter.
// Depends on sb2d_pkg and sb2d_chain.
//
// A value is taken when start is high and busy is low. The block then
// shifts the magnitude bit by bit through the row of BCD cells (double
// dabble), sends the optional minus sign, and shifts the digits out of
// the cells, skipping leading zeros. Busy stays high while a value is
// converted and sent, and a new value is taken only once busy is low
// again. Each character appears for exactly one cycle with strobe high;
// there is no back-pressure, so the receiver must take every strobed
// character. The final character of a number has last set.
module signed_binary_to_decimal_ascii #(
    parameter int VALUE_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [VALUE_BITS-1:0] value,
    output logic                         strobe,
    output logic [7:0]                   character,
    output logic                         last
);
    import sb2d_pkg::*;

    localparam int NDIG   = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
    localparam int SCNT_W = $clog2(VALUE_BITS);
    localparam int DCNT_W = $clog2(NDIG);
    localparam logic [SCNT_W-1:0] SHIFT_LAST = SCNT_W'(VALUE_BITS - 1);
    localparam logic [DCNT_W-1:0] DIGIT_LAST = DCNT_W'(NDIG - 1);

    state_t                state_reg, state_next;
    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic                  neg_reg, neg_next;
    logic [SCNT_W-1:0]     shift_cnt_reg, shift_cnt_next;
    logic [DCNT_W-1:0]     digit_cnt_reg, digit_cnt_next;
    logic                  started_reg, started_next;

    cell_ctrl_t            ctrl;
    logic [DIGIT_BITS-1:0] top_digit;
    logic [VALUE_BITS-1:0] magnitude;
    logic                  emit;

    assign magnitude = value[VALUE_BITS-1] ? (~value + 1'b1) : value;

    sb2d_chain #(
        .NDIG (NDIG)
    ) u_chain (
        .clk       (clk),
        .ctrl      (ctrl),
        .bin_bit   (mag_reg[VALUE_BITS-1]),
        .top_digit (top_digit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg       <= mag_next;
        neg_reg       <= neg_next;
        shift_cnt_reg <= shift_cnt_next;
        digit_cnt_reg <= digit_cnt_next;
        started_reg   <= started_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        shift_cnt_next = shift_cnt_reg;
        digit_cnt_next = digit_cnt_reg;
        started_next   = started_reg;
        ctrl           = '0;
        busy           = 1'b1;
        strobe         = 1'b0;
        character      = CHAR_ZERO + {4'b0000, top_digit};
        last           = 1'b0;
        emit           = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    mag_next       = magnitude;
                    neg_next       = value[VALUE_BITS-1];
                    shift_cnt_next = SHIFT_LAST;
                    ctrl.clear     = 1'b1;
                    state_next     = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                ctrl.dabble = 1'b1;
                mag_next    = {mag_reg[VALUE_BITS-2:0], 1'b0};
                if (shift_cnt_reg == '0)
                begin
                    state_next = ST_SIGN;
                end
                else
                begin
                    shift_cnt_next = shift_cnt_reg - 1'b1;
                end
            end
            ST_SIGN:
            begin
                strobe         = neg_reg;
                character      = CHAR_MINUS;
                digit_cnt_next = DIGIT_LAST;
                started_next   = 1'b0;
                state_next     = ST_EMIT;
            end
            ST_EMIT:
            begin
                // skip leading zeros, always emit the units digit
                ctrl.shift_digit = 1'b1;
                emit             = started_reg || (top_digit != '0) || (digit_cnt_reg == '0);
                strobe           = emit;
                last             = (digit_cnt_reg == '0);
                started_next     = started_reg || emit;
                if (digit_cnt_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    digit_cnt_next = digit_cnt_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/sb2d_checker.sv -----
// Port-level checker for signed_binary_to_decimal_ascii, bound to the top level.
// Depends on assert_macros.svh and sb2d_pkg.
`include "assert_macros.svh"

module sb2d_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       strobe,
    input logic [7:0] character,
    input logic       last
);
    import sb2d_pkg::*;

    `SB2D_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy, "no busy after transfer")
    `SB2D_ASSERT_IMP(a_strobe_busy, clk, rst_n, strobe, busy, "strobe while idle")
    `SB2D_ASSERT_NXT(a_last_quiet, clk, rst_n, strobe && last, !strobe, "strobe right after last")
    `SB2D_ASSERT_IMP(a_minus_not_last, clk, rst_n, strobe && (character == CHAR_MINUS),
                     !last, "sign marked last")
    `SB2D_ASSERT_IMP(a_done_last, clk, rst_n, $fell(busy), $past(strobe && last),
                     "idle without last")

endmodule

bind signed_binary_to_decimal_ascii sb2d_checker u_sb2d_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .strobe    (strobe),
    .character (character),
    .last      (last)
);
